// ----- rtl/core/pgr_pkg.sv -----
// Shared types, constants and the 5x7 font for the page framebuffer glyph renderer.
package pgr_pkg;

   localparam int DEF_DISPLAY_WIDTH  = 128;
   localparam int DEF_DISPLAY_HEIGHT = 64;
   localparam int GLYPH_COUNT        = 72;
   localparam int GLYPH_IDX_W        = 7;

   typedef enum logic [2:0] {
      OP_SET_PIXEL    = 3'd0,
      OP_CLEAR_PIXEL  = 3'd1,
      OP_INVERT_PIXEL = 3'd2,
      OP_GLYPH        = 3'd3,
      OP_GLYPH_X2     = 3'd4,
      OP_CLEAR_ALL    = 3'd5,
      OP_READ_BYTE    = 3'd6
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_MODIFY,
      ST_FETCH,
      ST_FINISH
   } state_type;

   // One row per glyph, column 0 in the top byte, top pixel row in bit 0.
   localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
      40'h0000000000, // space
      40'h00005F0000, // !
      40'h2313086462, // %
      40'h0004070400, // +
      40'h0060600000, // ,
      40'h0004040400, // -
      40'h0060600000, // .
      40'h2010080402, // /
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E,
      40'h0036360000, // :
      40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
      40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
      40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
      40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
      40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
      40'h0708700807, 40'h6151494543,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F,
      40'h3854545418, 40'h087E090102, 40'h0C5252523E, 40'h7F08040478,
      40'h00447D4000, 40'h0000000000, 40'h20403D0402, 40'h00417F4000,
      40'h7C04180478, 40'h7C08040478, 40'h3844444438, 40'h7C14141408,
      40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844,
      40'h0C5050503C, 40'h4464544C44,
      40'h0609060000  // degree sign
   };

   // Map a character code to its font row; anything without a glyph maps to space.
   function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [7:0] c);
      logic [GLYPH_IDX_W-1:0] idx;
      idx = '0;
      priority if (c >= 8'h30 && c <= 8'h39) idx = GLYPH_IDX_W'(c - 8'h28);
      else if (c >= 8'h41 && c <= 8'h5A)     idx = GLYPH_IDX_W'(c - 8'h2E);
      else if (c >= 8'h61 && c <= 8'h7A)     idx = GLYPH_IDX_W'(c - 8'h34);
      else if (c == 8'h21)                   idx = GLYPH_IDX_W'(1);
      else if (c == 8'h25)                   idx = GLYPH_IDX_W'(2);
      else if (c == 8'h2B)                   idx = GLYPH_IDX_W'(3);
      else if (c == 8'h2C)                   idx = GLYPH_IDX_W'(4);
      else if (c == 8'h2D)                   idx = GLYPH_IDX_W'(5);
      else if (c == 8'h2E)                   idx = GLYPH_IDX_W'(6);
      else if (c == 8'h2F)                   idx = GLYPH_IDX_W'(7);
      else if (c == 8'h3A)                   idx = GLYPH_IDX_W'(18);
      else if (c == 8'hB0)                   idx = GLYPH_IDX_W'(71);
      else                                   idx = '0;
      return idx;
   endfunction

   // Fetch one column byte of a glyph.
   function automatic logic [7:0] glyph_column(input logic [GLYPH_IDX_W-1:0] idx,
                                               input logic [2:0] col);
      logic [39:0] row;
      row = GLYPH_ROM[idx];
      return row[8 * (4 - int'(col)) +: 8];
   endfunction

endpackage

// ----- rtl/core/pgr_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module pgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/page_framebuffer_glyph_renderer.sv -----
// Top level: page-mode monochrome framebuffer with pixel, 5x7 glyph, clear and read commands.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  opcode, pos_x, pos_y, char_code, byte_index
//   rsp      out        rsp_valid / rsp_ready  read_data
//
// The single frame RAM port pair serialises the work: a drawing command reads each touched
// byte and then writes it back, and clear all writes every byte of the store.
// Reset starts a clearing pass over all STORE_BYTES bytes; req_ready stays low meanwhile.
// The result register lets the next command transfer in while a result waits on rsp_ready;
// that command's own result is held back until the register frees up.
module page_framebuffer_glyph_renderer
   import pgr_pkg::*;
#(
   parameter int DISPLAY_WIDTH  = DEF_DISPLAY_WIDTH,
   parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_opcode,
   input  logic signed [8:0] req_pos_x,
   input  logic signed [8:0] req_pos_y,
   input  logic [7:0]        req_char_code,
   input  logic [9:0]        req_byte_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_data
);

   localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam logic signed [11:0] W_S = 12'(DISPLAY_WIDTH);
   localparam logic signed [11:0] H_S = 12'(DISPLAY_HEIGHT);

   // Control state
   state_type              state_ff, state_in;
   logic                   boot_ff;
   logic [ADDR_W-1:0]      clr_ff;
   logic [3:0]             col_ff;
   logic [1:0]             k_ff;
   logic                   rsp_valid_ff;

   // Command and work registers
   opcode_type             op_ff;
   logic signed [8:0]      x_ff, y_ff;
   logic [GLYPH_IDX_W-1:0] gidx_ff;
   logic [7:0]             set_ff, clr_mask_ff, xor_ff;
   logic [ADDR_W-1:0]      mod_addr_ff;
   logic [7:0]             result_ff;
   logic [7:0]             rsp_data_ff;

   // RAM port signals
   logic                   ram_we, ram_re;
   logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
   logic [7:0]             ram_wdata, ram_rdata;

   logic                   accept, out_free, clr_last, read_ok;
   logic                   step_hit, step_last;
   logic [3:0]             col_max;
   logic [1:0]             k_max;
   logic                   is_double;
   logic signed [11:0]     x_ext, y_ext, cx_s, page_s;
   logic [2:0]             gcol;
   logic [7:0]             gbyte;
   logic                   col_ok;
   logic [7:0]             set_m, clr_m, xor_m;
   logic [PAGE_W-1:0]      page_u;
   logic [8:0]             cx_u;
   logic [ADDR_W-1:0]      step_addr;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign clr_last  = (clr_ff == ADDR_W'(STORE_BYTES - 1));
   assign read_ok   = int'(req_byte_index) < STORE_BYTES;
   assign is_double = (op_ff == OP_GLYPH_X2);

   // Sweep bounds: pixel ops touch one byte, a glyph 5 columns x 2 pages,
   // a doubled glyph 10 columns x 3 pages.
   always_comb begin
      unique case (op_ff)
         OP_GLYPH: begin
            col_max = 4'd4;
            k_max   = 2'd1;
         end
         OP_GLYPH_X2: begin
            col_max = 4'd9;
            k_max   = 2'd2;
         end
         default: begin
            col_max = 4'd0;
            k_max   = 2'd0;
         end
      endcase
   end

   assign step_last = (col_ff == col_max) && (k_ff == k_max);

   // Per-byte masks for the current column and page of the sweep.
   assign x_ext  = {{3{x_ff[8]}}, x_ff};
   assign y_ext  = {{3{y_ff[8]}}, y_ff};
   assign cx_s   = x_ext + signed'(12'(col_ff));
   assign page_s = (y_ext >>> 3) + signed'(12'(k_ff));
   assign gcol   = is_double ? col_ff[3:1] : col_ff[2:0];
   assign gbyte  = glyph_column(gidx_ff, gcol);
   assign col_ok = (cx_s >= 0) && (cx_s < W_S);

   always_comb begin
      set_m = '0;
      clr_m = '0;
      xor_m = '0;
      for (int b = 0; b < 8; b++) begin
         logic signed [11:0] row_s;
         logic signed [11:0] grow_s;
         row_s  = (page_s <<< 3) + signed'(12'(b));
         grow_s = row_s - y_ext;
         if (col_ok && row_s >= 0 && row_s < H_S) begin
            unique case (op_ff)
               OP_SET_PIXEL:    set_m[b] = (grow_s == 0);
               OP_CLEAR_PIXEL:  clr_m[b] = (grow_s == 0);
               OP_INVERT_PIXEL: xor_m[b] = (grow_s == 0);
               OP_GLYPH: begin
                  // Opaque: lit bits set, dark bits clear.
                  if (grow_s >= 0 && grow_s < 7) begin
                     set_m[b] = gbyte[grow_s[2:0]];
                     clr_m[b] = !gbyte[grow_s[2:0]];
                  end
               end
               OP_GLYPH_X2: begin
                  // Each font pixel covers a 2x2 block; only set.
                  if (grow_s >= 0 && grow_s < 14) begin
                     set_m[b] = gbyte[grow_s[3:1]];
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Any mask bit implies the page and column are on screen.
   assign step_hit  = |(set_m | clr_m | xor_m);
   assign page_u    = page_s[PAGE_W-1:0];
   assign cx_u      = cx_s[8:0];
   assign step_addr = ADDR_W'(32'(page_u) * 32'(DISPLAY_WIDTH) + 32'(cx_u));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = boot_ff ? ST_IDLE : ST_FINISH;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (opcode_type'(req_opcode))
                  OP_SET_PIXEL, OP_CLEAR_PIXEL, OP_INVERT_PIXEL,
                  OP_GLYPH, OP_GLYPH_X2: state_in = ST_STEP;
                  OP_CLEAR_ALL:          state_in = ST_CLEAR;
                  OP_READ_BYTE:          state_in = read_ok ? ST_FETCH : ST_FINISH;
                  default:               state_in = ST_FINISH;
               endcase
            end
         end
         ST_STEP: begin
            priority if (step_hit) state_in = ST_MODIFY;
            else if (step_last)    state_in = ST_FINISH;
            else                   state_in = ST_STEP;
         end
         ST_MODIFY: state_in = step_last ? ST_FINISH : ST_STEP;
         ST_FETCH:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Outputs and RAM port control
   always_comb begin
      req_ready = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = mod_addr_ff;
      ram_wdata = ((ram_rdata | set_ff) & ~clr_mask_ff) ^ xor_ff;
      ram_re    = 1'b0;
      ram_raddr = step_addr;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            // Read issued speculatively; only a read command uses the data.
            req_ready = 1'b1;
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(req_byte_index);
         end
         ST_STEP:   ram_re = step_hit;
         ST_MODIFY: ram_we = 1'b1;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         boot_ff      <= 1'b1;
         clr_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_CLEAR: begin
               if (clr_last) begin
                  clr_ff  <= '0;
                  boot_ff <= 1'b0;
               end else begin
                  clr_ff <= clr_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  col_ff <= '0;
                  k_ff   <= '0;
                  clr_ff <= '0;
               end
            end
            ST_STEP, ST_MODIFY: begin
               // Advance page first, then column; hold while a byte is in flight.
               if (state_ff == ST_MODIFY || !step_hit) begin
                  if (k_ff == k_max) begin
                     k_ff   <= '0;
                     col_ff <= col_ff + 1'b1;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept) begin
         op_ff     <= opcode_type'(req_opcode);
         x_ff      <= req_pos_x;
         y_ff      <= req_pos_y;
         gidx_ff   <= glyph_index(req_char_code);
         result_ff <= '0;
      end
      if (state_ff == ST_STEP && step_hit) begin
         set_ff      <= set_m;
         clr_mask_ff <= clr_m;
         xor_ff      <= xor_m;
         mod_addr_ff <= step_addr;
      end
      if (state_ff == ST_FETCH) begin
         result_ff <= ram_rdata;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_data_ff <= result_ff;
      end
   end

   pgr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// ----- rtl/core/pgr_checker.sv -----
// Port-level checks for the page framebuffer glyph renderer, bound to the top level.
module pgr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data
);

   logic [1:0] pending_ff;

   // Count commands taken but not yet answered.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 2'((req_valid && req_ready) ? 1 : 0)
                                  - 2'((rsp_valid && rsp_ready) ? 1 : 0);
      end
   end

   a_boot_sweep: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("result dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken in back-to-back cycles");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two commands outstanding");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result with no command outstanding");

endmodule

bind page_framebuffer_glyph_renderer pgr_checker u_pgr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_read_data (rsp_read_data)
);

// ----- dv/page_framebuffer_glyph_renderer_tb.sv -----
// Self-checking testbench for the page framebuffer glyph renderer: directed and random commands.
module page_framebuffer_glyph_renderer_tb;
   import pgr_pkg::*;

   // Geometry of the default build; the shadow frame follows the same page layout.
   localparam int DISPLAY_W   = DEF_DISPLAY_WIDTH;
   localparam int DISPLAY_H   = DEF_DISPLAY_HEIGHT;
   localparam int STORE_BYTES = DISPLAY_W * ((DISPLAY_H + 7) / 8);
   localparam int FONT_ROWS   = 72;

   // The one opcode value that has no command behind it.
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam logic [7:0] DEGREE_CODE = 8'hB0;

   // Cycles to let pass after the last result: a full clear is the slowest command.
   localparam int DRAIN_CYCLES = 1100;

   // Font of the renderer: column 0 in the top byte, top pixel row in bit 0 of each byte.
   localparam logic [39:0] FONT_COLUMNS [FONT_ROWS] = '{
      40'h0000000000, 40'h00005F0000, 40'h2313086462, 40'h0004070400,
      40'h0060600000, 40'h0004040400, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000,
      40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
      40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
      40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
      40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
      40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
      40'h0708700807, 40'h6151494543,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F,
      40'h3854545418, 40'h087E090102, 40'h0C5252523E, 40'h7F08040478,
      40'h00447D4000, 40'h0000000000, 40'h20403D0402, 40'h00417F4000,
      40'h7C04180478, 40'h7C08040478, 40'h3844444438, 40'h7C14141408,
      40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844,
      40'h0C5050503C, 40'h4464544C44,
      40'h0609060000
   };

   typedef enum {PLOT_SET, PLOT_CLEAR, PLOT_FLIP} plot_mode_t;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [2:0]        req_opcode;
   logic signed [8:0] req_pos_x;
   logic signed [8:0] req_pos_y;
   logic [7:0]        req_char_code;
   logic [9:0]        req_byte_index;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [7:0]        rsp_read_data;

   // Shadow copy of the frame store, updated as each command transfers in.
   logic [7:0] frame_shadow [STORE_BYTES];
   // Read data still owed by the block, oldest first.
   logic [7:0] pending_read_data [$];

   int  check_failures = 0;
   int  results_seen   = 0;
   bit  idle_on        = 1'b1;
   int  rsp_hold_request = 0;
   logic [7:0] oldest_read_data;

   // ASCII characters that have their own glyph; other codes, but for the degree sign, fall back to a space.
   string glyph_chars =
      "!%+,-./0123456789:ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

   page_framebuffer_glyph_renderer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_char_code  (req_char_code),
      .req_byte_index (req_byte_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Shadow frame model
   // ---------------------------------------------------------------------------------------

   function automatic void clear_shadow();
      foreach (frame_shadow[i]) frame_shadow[i] = '0;
   endfunction

   // Touch one pixel; anything off the visible area is dropped on its own.
   function automatic void plot(int x, int y, plot_mode_t mode);
      int         addr;
      logic [7:0] mask;
      if (x < 0 || x >= DISPLAY_W || y < 0 || y >= DISPLAY_H) return;
      addr = (y / 8) * DISPLAY_W + x;
      if (addr >= STORE_BYTES) return;
      mask = 8'(1 << (y % 8));
      case (mode)
         PLOT_SET:   frame_shadow[addr] = frame_shadow[addr] | mask;
         PLOT_CLEAR: frame_shadow[addr] = frame_shadow[addr] & ~mask;
         default:    frame_shadow[addr] = frame_shadow[addr] ^ mask;
      endcase
   endfunction

   // Map a character to its font row: digits, both letter cases, a few marks and degree.
   function automatic int font_row(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 8 + int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h5A) return 19 + int'(c) - 'h41;
      if (c >= 8'h61 && c <= 8'h7A) return 45 + int'(c) - 'h61;
      case (c)
         8'h21:       return 1;   // !
         8'h25:       return 2;   // %
         8'h2B:       return 3;   // +
         8'h2C:       return 4;   // ,
         8'h2D:       return 5;   // -
         8'h2E:       return 6;   // .
         8'h2F:       return 7;   // /
         8'h3A:       return 18;  // :
         DEGREE_CODE: return 71;
         default:     return 0;
      endcase
   endfunction

   // Plain glyphs are opaque over their 5x7 cell; doubled glyphs only set 2x2 blocks.
   function automatic void draw_shadow_glyph(int x0, int y0, logic [7:0] c, bit doubled);
      logic [39:0] cols;
      logic [7:0]  bits;
      cols = FONT_COLUMNS[font_row(c)];
      for (int col = 0; col < 5; col++) begin
         bits = cols[8 * (4 - col) +: 8];
         for (int row = 0; row < 7; row++) begin
            if (!doubled) begin
               plot(x0 + col, y0 + row, bits[row] ? PLOT_SET : PLOT_CLEAR);
            end else if (bits[row]) begin
               for (int d = 0; d < 4; d++)
                  plot(x0 + 2 * col + (d & 1), y0 + 2 * row + (d >> 1), PLOT_SET);
            end
         end
      end
   endfunction

   // Apply one command to the shadow frame and return the byte the block must answer.
   function automatic logic [7:0] predict_read_data(logic [2:0] op, logic signed [8:0] x,
                                                    logic signed [8:0] y, logic [7:0] c,
                                                    logic [9:0] idx);
      logic [7:0] data;
      data = '0;
      case (op)
         OP_SET_PIXEL:    plot(int'(x), int'(y), PLOT_SET);
         OP_CLEAR_PIXEL:  plot(int'(x), int'(y), PLOT_CLEAR);
         OP_INVERT_PIXEL: plot(int'(x), int'(y), PLOT_FLIP);
         OP_GLYPH:        draw_shadow_glyph(int'(x), int'(y), c, 1'b0);
         OP_GLYPH_X2:     draw_shadow_glyph(int'(x), int'(y), c, 1'b1);
         OP_CLEAR_ALL:    clear_shadow();
         OP_READ_BYTE:    if (int'(idx) < STORE_BYTES) data = frame_shadow[idx];
         default:         ;
      endcase
      return data;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Handshake helpers
   // ---------------------------------------------------------------------------------------

   // Idle length in cycles: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Drive one command, hold it until the transfer, then record its expected read data.
   // Valid stays high on return so a back-to-back command needs no second drive of valid.
   task automatic send_command(logic [2:0] op, logic signed [8:0] x, logic signed [8:0] y,
                               logic [7:0] c, logic [9:0] idx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_pos_x      <= x;
      req_pos_y      <= y;
      req_char_code  <= c;
      req_byte_index <= idx;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_read_data.push_back(predict_read_data(op, x, y, c, idx));
   endtask

   // Read command with junk in the fields that a read ignores.
   task automatic send_read(logic [9:0] idx);
      send_command(OP_READ_BYTE, 9'($urandom), 9'($urandom), 8'($urandom), idx);
   endtask

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 19);
      if (r < 15) return 8'(glyph_chars[$urandom_range(0, glyph_chars.len() - 1)]);
      if (r < 16) return DEGREE_CODE;
      return 8'($urandom_range(0, 255));
   endfunction

   // Byte address of a visible pixel, or a random address if it falls off the frame.
   function automatic logic [9:0] byte_of(int x, int y);
      if (x < 0 || x >= DISPLAY_W || y < 0 || y >= DISPLAY_H) return 10'($urandom);
      return 10'((y / 8) * DISPLAY_W + x);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result side: random stalls, plus a long hold when a test asks for one
   // ---------------------------------------------------------------------------------------

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            stall_left       = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare every result transfer with the oldest expected read data.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_read_data.size() == 0) begin
            check_failures++;
            if (check_failures <= 10)
               $display("result %0d: read_data %02h arrived with nothing expected",
                        results_seen, rsp_read_data);
         end else begin
            oldest_read_data = pending_read_data.pop_front();
            if (rsp_read_data !== oldest_read_data) begin
               check_failures++;
               if (check_failures <= 10)
                  $display("result %0d: read_data expected %02h, got %02h",
                           results_seen, oldest_read_data, rsp_read_data);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // The store is cleared by reset: both ends of it read back zero.
   task automatic test_reset_state();
      send_read(10'd0);
      send_read(10'd1023);
   endtask

   // Corners, pixels just off the left and right edges, extreme coordinates, invert and clear.
   task automatic test_pixel_commands();
      send_command(OP_SET_PIXEL, 9'sd0, 9'sd0, 8'h00, 10'd0);
      send_command(OP_SET_PIXEL, 9'sd127, 9'sd63, 8'hFF, 10'd1023);
      send_command(OP_SET_PIXEL, -9'sd1, 9'sd0, 8'h00, 10'd0);
      send_command(OP_SET_PIXEL, 9'sd128, 9'sd63, 8'h00, 10'd0);
      send_command(OP_SET_PIXEL, 9'sd255, -9'sd256, 8'h00, 10'd0);
      send_command(OP_SET_PIXEL, -9'sd256, 9'sd255, 8'h00, 10'd0);
      send_command(OP_INVERT_PIXEL, 9'sd127, 9'sd63, 8'h00, 10'd0);
      send_command(OP_INVERT_PIXEL, 9'sd5, 9'sd9, 8'h00, 10'd0);
      send_read(10'd1023);
      send_read(10'd133);
      send_command(OP_CLEAR_PIXEL, 9'sd0, 9'sd0, 8'h00, 10'd0);
      send_read(10'd0);
   endtask

   // Opaque glyph, degree sign hanging off the top left, doubled glyph clipped at the
   // bottom right, lowercase j and a code with no glyph (both draw as a space).
   task automatic test_glyph_commands();
      send_command(OP_GLYPH, 9'sd0, 9'sd8, 8'h41, 10'd0);
      send_read(10'd130);
      send_command(OP_GLYPH, -9'sd2, -9'sd3, DEGREE_CODE, 10'd0);
      send_read(10'd0);
      send_command(OP_GLYPH_X2, 9'sd120, 9'sd56, 8'h25, 10'd0);
      send_read(10'd1017);
      send_command(OP_GLYPH, 9'sd0, 9'sd8, 8'h6A, 10'd0);
      send_command(OP_GLYPH, -9'sd256, 9'sd255, 8'hFF, 10'd0);
   endtask

   // Unused opcode leaves the frame alone; clear all wipes it.
   task automatic test_clear_and_unused();
      send_command(OP_UNUSED, 9'h1FF, 9'h1FF, 8'hFF, 10'h3FF);
      send_command(OP_CLEAR_ALL, 9'sd0, 9'sd0, 8'h00, 10'd0);
      send_read(10'd130);
   endtask

   // Hold results off for a long stretch while commands keep coming, so the result
   // register fills and the block has to stall its command side.
   task automatic test_result_backpressure();
      int x, y;
      idle_on          = 1'b0;
      rsp_hold_request = 400;
      for (int i = 0; i < 8; i++) begin
         x = $urandom_range(0, DISPLAY_W - 1);
         y = $urandom_range(0, DISPLAY_H - 1);
         send_command(OP_INVERT_PIXEL, 9'(x), 9'(y), 8'h00, 10'd0);
         send_read(byte_of(x, y));
      end
      idle_on = 1'b1;
   endtask

   // Mostly draw-then-read-back sequences near the drawn spot, some clears, some noise.
   task automatic test_random_traffic(int item_goal);
      int         sent;
      int         pick, ax, ay, dx, dy, reads;
      logic [2:0] op;
      sent = 0;
      while (sent < item_goal) begin
         // Run a middle stretch with no idling on either side.
         idle_on = !(sent >= item_goal / 3 && sent < item_goal / 2);
         pick    = $urandom_range(0, 99);
         if (pick < 8) begin
            send_command(3'($urandom), 9'($urandom), 9'($urandom), 8'($urandom),
                         10'($urandom));
            sent++;
         end else if (pick < 9) begin
            send_command(OP_CLEAR_ALL, 9'($urandom), 9'($urandom), 8'($urandom),
                         10'($urandom));
            send_read(10'($urandom));
            sent += 2;
         end else begin
            if ($urandom_range(0, 9) == 0) begin
               ax = $urandom_range(0, 511) - 256;
               ay = $urandom_range(0, 511) - 256;
            end else begin
               ax = $urandom_range(0, DISPLAY_W + 19) - 12;
               ay = $urandom_range(0, DISPLAY_H + 19) - 12;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)      op = 3'($urandom_range(OP_SET_PIXEL, OP_INVERT_PIXEL));
            else if (pick < 75) op = OP_GLYPH;
            else                op = OP_GLYPH_X2;
            send_command(op, 9'(ax), 9'(ay), pick_char(), 10'($urandom));
            sent++;
            // Read back bytes the command may have touched.
            reads = $urandom_range(1, 3);
            for (int k = 0; k < reads; k++) begin
               dx = 0;
               dy = 0;
               if (op == OP_GLYPH) begin
                  dx = $urandom_range(0, 4);
                  dy = $urandom_range(0, 6);
               end else if (op == OP_GLYPH_X2) begin
                  dx = $urandom_range(0, 9);
                  dy = $urandom_range(0, 13);
               end
               send_read(byte_of(ax + dx, ay + dy));
               sent++;
            end
         end
      end
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_SET_PIXEL;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_char_code  = '0;
      req_byte_index = '0;
      clear_shadow();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_pixel_commands();
      test_glyph_commands();
      test_clear_and_unused();
      test_result_backpressure();
      test_random_traffic(1800);

      // Drop valid at the last transfer, then drain and watch for stray results.
      req_valid <= 1'b0;
      idle_on   = 1'b0;
      while (pending_read_data.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (check_failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of the sequence above.
   initial begin
      #8_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/pgr_pkg.sv
rtl/core/pgr_ram.sv
rtl/core/page_framebuffer_glyph_renderer.sv
rtl/core/pgr_checker.sv
dv/page_framebuffer_glyph_renderer_tb.sv
